// ===== design/ptg_pkg.sv =====
// ----------------------------------------------------------------------------
// ptg_pkg: shared types and constants of the padded tile gather generator
// Tile geometry, processing element count, field widths, configuration
// register indexes and the structs passed between the walker and the
// address pipeline.
// ----------------------------------------------------------------------------
package ptg_pkg;

  // tile geometry and processing element count
  localparam int TILE_DEPTH = 16;
  localparam int TILE_SIDE  = 16;
  localparam int NUM_PE     = 2;

  // configuration ceilings
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_MAP      = 256;

  // configuration and field widths
  localparam int CFG_W   = 11;  // channel registers and write data
  localparam int MAP_W   = 9;   // map side length
  localparam int CH_W    = 10;  // channel index
  localparam int BASE_W  = 9;   // row and column tile bases
  localparam int POS_W   = 9;   // row and column positions, stored plus one
  localparam int COORD_W = $clog2(MAX_MAP);  // in-map row or column
  localparam int ADDR_W  = 26;

  // widths for the walker's compare arithmetic
  localparam int CH_CALC_W = 12;
  localparam int SP_CALC_W = 11;
  localparam int PE_W      = $clog2(NUM_PE + 1);
  localparam int REP_W     = $clog2(TILE_DEPTH + 1);

  // widths of the address products
  localparam int CHL_W  = CH_W + MAP_W;
  localparam int RC_W   = COORD_W + MAP_W;
  localparam int PROD_W = CHL_W + MAP_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE         = 2'd0,
    CFG_CHANNELS_IN  = 2'd1,
    CFG_CHANNELS_OUT = 2'd2,
    CFG_MAP_LENGTH   = 2'd3
  } ptg_cfg_idx_e;

  // configuration after clamping to the supported range
  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] ch_in;
    logic [CFG_W-1:0] ch_out;
    logic [MAP_W-1:0] map_len;
  } ptg_cfg_t;

  // one walk entry, coordinates zero for pad and invalid entries
  typedef struct packed {
    logic               entry_valid;
    logic               pad;
    logic               seg_end;
    logic               last;
    logic [CH_W-1:0]    chan;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } ptg_entry_t;

endpackage

// ===== design/ptg_walker.sv =====
// ----------------------------------------------------------------------------
// ptg_walker: tile walk counters
// Holds the nested tile and position counters, steps them once per input
// transfer and registers the resulting entry for the address pipeline.
// ----------------------------------------------------------------------------
module ptg_walker
  import ptg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ptg_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       restart_i,
  output logic       s1_valid_o,
  input  logic       s1_ready_i,
  output ptg_entry_t s1_entry_o
);

  // walk state, positions stored plus one so the halo column is zero
  logic [PE_W-1:0]   pe_q, pe_d, e_pe;
  logic [CH_W-1:0]   ctb_q, ctb_d, e_ctb;
  logic [BASE_W-1:0] rtb_q, rtb_d, e_rtb;
  logic [BASE_W-1:0] cbase_q, cbase_d, e_cbase;
  logic [REP_W-1:0]  rep_q, rep_d, e_rep;
  logic [CH_W-1:0]   cp_q, cp_d, e_cp;
  logic [POS_W-1:0]  rowb_q, rowb_d, e_rowb;
  logic [POS_W-1:0]  colb_q, colb_d, e_colb;
  logic              done_q, done_d, e_done;

  logic                 in_fire;
  logic                 s1_valid_q;
  ptg_entry_t           s1_q, s1_d;

  logic [CFG_W-1:0]     dout_cap;
  logic [REP_W-1:0]     reps, rep_inc;
  logic [PE_W-1:0]      pe_inc;
  logic [CH_CALC_W-1:0] dpe, seg_lo, seg_hi, chan_end, ctb_inc, ch_inc, t_ctb;
  logic [SP_CALC_W-1:0] map_l, row_end, col_end, rtb_inc, cb_inc;
  logic [SP_CALC_W-1:0] row_x, col_x, row_inc, col_inc, t_rtb, t_cbase;
  logic [POS_W-1:0]     row_m1, col_m1;
  logic                 ok, pad, step, next_tile, seg_end, last;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || s1_ready_i;

  // restart overrides the stored walk
  always_comb begin
    if (restart_i) begin
      e_pe    = '0;
      e_ctb   = '0;
      e_rtb   = '0;
      e_cbase = '0;
      e_rep   = '0;
      e_cp    = '0;
      e_rowb  = '0;
      e_colb  = '0;
      e_done  = 1'b0;
    end else begin
      e_pe    = pe_q;
      e_ctb   = ctb_q;
      e_rtb   = rtb_q;
      e_cbase = cbase_q;
      e_rep   = rep_q;
      e_cp    = cp_q;
      e_rowb  = rowb_q;
      e_colb  = colb_q;
      e_done  = done_q;
    end
  end

  // sequence bounds
  always_comb begin
    dout_cap = (cfg_i.ch_out < CFG_W'(TILE_DEPTH)) ? cfg_i.ch_out : CFG_W'(TILE_DEPTH);
    reps     = REP_W'(dout_cap / NUM_PE);
    dpe      = CH_CALC_W'(cfg_i.ch_in / NUM_PE);
    pe_inc   = e_pe + PE_W'(1);
    seg_lo   = cfg_i.mode ? CH_CALC_W'(e_pe) * dpe : '0;
    seg_hi   = cfg_i.mode ? CH_CALC_W'(pe_inc) * dpe : CH_CALC_W'(cfg_i.ch_in);
    map_l    = SP_CALC_W'(cfg_i.map_len);
    ctb_inc  = CH_CALC_W'(e_ctb) + CH_CALC_W'(TILE_DEPTH);
    rtb_inc  = SP_CALC_W'(e_rtb) + SP_CALC_W'(TILE_SIDE);
    cb_inc   = SP_CALC_W'(e_cbase) + SP_CALC_W'(TILE_SIDE);
    chan_end = (ctb_inc < seg_hi) ? ctb_inc : seg_hi;
    row_end  = (rtb_inc < map_l) ? rtb_inc : map_l;
    col_end  = (cb_inc < map_l) ? cb_inc : map_l;
    row_x    = SP_CALC_W'(e_rowb);
    col_x    = SP_CALC_W'(e_colb);
  end

  // the current state must lie inside the configured walk
  always_comb begin
    ok = (map_l != '0) && (seg_lo < seg_hi)
         && (CH_CALC_W'(e_ctb) >= seg_lo) && (CH_CALC_W'(e_ctb) < seg_hi)
         && (SP_CALC_W'(e_rtb) < map_l) && (SP_CALC_W'(e_cbase) < map_l)
         && (cfg_i.mode ? (e_pe < PE_W'(NUM_PE)) : (e_rep < reps))
         && (e_cp >= e_ctb) && (CH_CALC_W'(e_cp) < chan_end)
         && (row_x >= SP_CALC_W'(e_rtb)) && (row_x <= row_end + SP_CALC_W'(1))
         && (col_x >= SP_CALC_W'(e_cbase)) && (col_x <= col_end + SP_CALC_W'(1));
    step = !e_done && ok;
    pad  = (row_x == '0) || (row_x > map_l) || (col_x == '0) || (col_x > map_l);
  end

  // advance column, row, channel, repeat, then tile
  always_comb begin
    col_inc   = col_x + SP_CALC_W'(1);
    row_inc   = row_x + SP_CALC_W'(1);
    ch_inc    = CH_CALC_W'(e_cp) + CH_CALC_W'(1);
    rep_inc   = e_rep + REP_W'(1);
    t_ctb     = CH_CALC_W'(e_ctb);
    t_rtb     = SP_CALC_W'(e_rtb);
    t_cbase   = SP_CALC_W'(e_cbase);
    next_tile = 1'b0;
    seg_end   = 1'b0;
    last      = 1'b0;
    pe_d      = e_pe;
    ctb_d     = e_ctb;
    rtb_d     = e_rtb;
    cbase_d   = e_cbase;
    rep_d     = e_rep;
    cp_d      = e_cp;
    rowb_d    = e_rowb;
    colb_d    = e_colb;
    if (step) begin
      if (col_inc > col_end + SP_CALC_W'(1)) begin
        colb_d = POS_W'(e_cbase);
        if (row_inc > row_end + SP_CALC_W'(1)) begin
          rowb_d = POS_W'(e_rtb);
          if (ch_inc >= chan_end) begin
            cp_d      = e_ctb;
            next_tile = 1'b1;
            if (!cfg_i.mode) begin
              if (rep_inc >= reps) begin
                rep_d = '0;
              end else begin
                rep_d     = rep_inc;
                next_tile = 1'b0;
              end
            end
          end else begin
            cp_d = CH_W'(ch_inc);
          end
        end else begin
          rowb_d = POS_W'(row_inc);
        end
      end else begin
        colb_d = POS_W'(col_inc);
      end
    end
    // move on to the next tile
    if (next_tile) begin
      if (cb_inc >= map_l) begin
        t_cbase = '0;
        if (rtb_inc >= map_l) begin
          t_rtb = '0;
          t_ctb = ctb_inc;
          if (ctb_inc >= seg_hi) begin
            if (!cfg_i.mode) begin
              last = 1'b1;
            end else begin
              seg_end = 1'b1;
              pe_d    = pe_inc;
              if (pe_inc >= PE_W'(NUM_PE)) begin
                last = 1'b1;
              end else begin
                t_ctb = seg_hi;
              end
            end
          end
        end else begin
          t_rtb = rtb_inc;
        end
      end else begin
        t_cbase = cb_inc;
      end
      ctb_d   = CH_W'(t_ctb);
      rtb_d   = BASE_W'(t_rtb);
      cbase_d = BASE_W'(t_cbase);
      cp_d    = CH_W'(t_ctb);
      rowb_d  = POS_W'(t_rtb);
      colb_d  = POS_W'(t_cbase);
    end
    done_d = e_done || !ok || last;
  end

  // entry for the address pipeline
  always_comb begin
    row_m1            = e_rowb - POS_W'(1);
    col_m1            = e_colb - POS_W'(1);
    s1_d.entry_valid  = step;
    s1_d.pad          = step && pad;
    s1_d.seg_end      = step && seg_end;
    s1_d.last         = step && last;
    s1_d.chan         = (step && !pad) ? e_cp : '0;
    s1_d.row          = (step && !pad) ? row_m1[COORD_W-1:0] : '0;
    s1_d.col          = (step && !pad) ? col_m1[COORD_W-1:0] : '0;
  end

  // walk state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q    <= '0;
      ctb_q   <= '0;
      rtb_q   <= '0;
      cbase_q <= '0;
      rep_q   <= '0;
      cp_q    <= '0;
      rowb_q  <= '0;
      colb_q  <= '0;
      done_q  <= 1'b0;
    end else if (in_fire) begin
      pe_q    <= pe_d;
      ctb_q   <= ctb_d;
      rtb_q   <= rtb_d;
      cbase_q <= cbase_d;
      rep_q   <= rep_d;
      cp_q    <= cp_d;
      rowb_q  <= rowb_d;
      colb_q  <= colb_d;
      done_q  <= done_d;
    end
  end

  // entry stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // entry stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_entry_o = s1_q;

  // a final entry leaves the walk finished
  a_last_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s1_d.last |=> done_q)
    else $error("walk not finished after final entry");

  // a finished walk stays finished until restarted
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && e_done |=> done_q)
    else $error("finished walk resumed without restart");

  // segment ends only come from the per-PE walk
  a_seg_end_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s1_d.seg_end |-> cfg_i.mode)
    else $error("segment end outside per-PE mode");

endmodule

// ===== design/ptg_addr_pipe.sv =====
// ----------------------------------------------------------------------------
// ptg_addr_pipe: word address pipeline
// Forms channel*L*L + row*L + col over two registered stages, two
// multiplications in the first stage and one in the second, and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module ptg_addr_pipe
  import ptg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MAP_W-1:0]  map_len_i,
  input  logic              s1_valid_i,
  output logic              s1_ready_o,
  input  ptg_entry_t        s1_entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] word_address_o,
  output logic              pad_zero_o,
  output logic              segment_end_o,
  output logic              sequence_last_o,
  output logic              entry_valid_o
);

  logic              s2_valid_q, s2_ready;
  logic              s2_ev_q, s2_pad_q, s2_seg_q, s2_last_q;
  logic [CHL_W-1:0]  s2_chl_q, s2_chl_d;
  logic [RC_W-1:0]   s2_rc_q, s2_rc_d;
  logic              s3_valid_q, s3_ready;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PROD_W-1:0] prod;
  logic              ev_q, pad_q, seg_q, last_q;

  // stage handshakes
  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready_o = s2_ready;

  // channel and row partial products
  always_comb begin
    s2_chl_d = CHL_W'(s1_entry_i.chan) * CHL_W'(map_len_i);
    s2_rc_d  = RC_W'(s1_entry_i.row) * RC_W'(map_len_i) + RC_W'(s1_entry_i.col);
  end

  // channel plane offset and final sum
  always_comb begin
    prod   = PROD_W'(s2_chl_q) * PROD_W'(map_len_i);
    addr_d = prod[ADDR_W-1:0] + ADDR_W'(s2_rc_q);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_i) begin
      s2_ev_q   <= s1_entry_i.entry_valid;
      s2_pad_q  <= s1_entry_i.pad;
      s2_seg_q  <= s1_entry_i.seg_end;
      s2_last_q <= s1_entry_i.last;
      s2_chl_q  <= s2_chl_d;
      s2_rc_q   <= s2_rc_d;
    end
    if (s3_ready && s2_valid_q) begin
      ev_q   <= s2_ev_q;
      pad_q  <= s2_pad_q;
      seg_q  <= s2_seg_q;
      last_q <= s2_last_q;
      addr_q <= addr_d;
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign word_address_o  = addr_q;
  assign pad_zero_o      = pad_q;
  assign segment_end_o   = seg_q;
  assign sequence_last_o = last_q;
  assign entry_valid_o   = ev_q;

  // pad entries carry a zero address
  a_pad_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pad_zero_o |-> word_address_o == '0)
    else $error("pad entry with nonzero address");

  // an entry past the end carries nothing
  a_invalid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> !pad_zero_o && !segment_end_o
      && !sequence_last_o && word_address_o == '0)
    else $error("invalid entry with fields set");

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_address_o)
      && $stable(pad_zero_o) && $stable(segment_end_o)
      && $stable(sequence_last_o) && $stable(entry_valid_o))
    else $error("result changed while stalled");

endmodule

// ===== design/padded_tile_gather_address_gen.sv =====
// ----------------------------------------------------------------------------
// padded_tile_gather_address_gen: halo-padded 16x16 tile gather addresses
// Pipeline: a result passes through the entry, partial product and address
//   registers and is held in the last until its output transfer.
// Throughput: one transfer per cycle while the output is not stalled.
// Reset: walk restarts from the first entry, configuration returns to
//   mode 0, 32 input and output channels, map side 112; pipeline empty.
// ----------------------------------------------------------------------------
module padded_tile_gather_address_gen
  import ptg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] word_address_o,
  output logic              pad_zero_o,
  output logic              segment_end_o,
  output logic              sequence_last_o,
  output logic              entry_valid_o
);

  logic             mode_q;
  logic [CFG_W-1:0] ch_in_q, ch_out_q;
  logic [MAP_W-1:0] map_len_q;
  ptg_cfg_t         cfg;
  logic             s1_valid, s1_ready;
  ptg_entry_t       s1_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      ch_in_q   <= CFG_W'(32);
      ch_out_q  <= CFG_W'(32);
      map_len_q <= MAP_W'(112);
    end else if (cfg_we_i) begin
      case (ptg_cfg_idx_e'(cfg_index_i))
        CFG_MODE:         mode_q    <= cfg_data_i[0];
        CFG_CHANNELS_IN:  ch_in_q   <= cfg_data_i;
        CFG_CHANNELS_OUT: ch_out_q  <= cfg_data_i;
        CFG_MAP_LENGTH:   map_len_q <= cfg_data_i[MAP_W-1:0];
        default:          mode_q    <= mode_q;
      endcase
    end
  end

  // clamp to the supported range
  always_comb begin
    cfg.mode    = mode_q;
    cfg.ch_in   = (ch_in_q > CFG_W'(MAX_CHANNELS)) ? CFG_W'(MAX_CHANNELS) : ch_in_q;
    cfg.ch_out  = (ch_out_q > CFG_W'(MAX_CHANNELS)) ? CFG_W'(MAX_CHANNELS) : ch_out_q;
    cfg.map_len = (map_len_q > MAP_W'(MAX_MAP)) ? MAP_W'(MAX_MAP) : map_len_q;
  end

  // tile walk
  ptg_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_entry_o (s1_entry)
  );

  // address arithmetic and result register
  ptg_addr_pipe u_addr_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .map_len_i       (cfg.map_len),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_entry_i      (s1_entry),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_address_o  (word_address_o),
    .pad_zero_o      (pad_zero_o),
    .segment_end_o   (segment_end_o),
    .sequence_last_o (sequence_last_o),
    .entry_valid_o   (entry_valid_o)
  );

endmodule
